// File: src/rbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_pkg: shared definitions for the ring buffer deque
// Depth of the ring store, derived widths, command and status codes, and the
// structures that pass between the controller, the store and the top level.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // Number of words in the ring store (2 .. 31).
  localparam int Depth = 16;
  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam int DataW = 32;
  localparam int CountOutW = 5;

  // Command codes carried on the input word.
  typedef enum logic [2:0] {
    CmdPushFront = 3'd0,
    CmdPopFront  = 3'd1,
    CmdPushRear  = 3'd2,
    CmdPopRear   = 3'd3,
    CmdClear     = 3'd4
  } cmd_e;

  // Status codes returned with every result word.
  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // Access to the ring store for one item.
  typedef struct packed {
    logic             we;
    logic             re;
    logic [PtrW-1:0]  addr;
    logic [DataW-1:0] wdata;
  } mem_req_t;

  // Result fields known when the item is taken; the popped word follows
  // from the store in the cycle after.
  typedef struct packed {
    logic                 pop;
    status_e              status;
    logic [CountOutW-1:0] count;
    logic                 empty;
    logic                 full;
  } res_t;

endpackage
`default_nettype wire

// File: src/rbd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_ram: single-port synchronous store
// One write or one read per cycle at a shared address; read data is
// registered and appears in the cycle after the request.
// ----------------------------------------------------------------------------
module rbd_ram #(
  parameter int Depth = 16,
  parameter int Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: src/rbd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_ctrl: pointer and count controller
// Holds the front and rear pointers and the word count, decodes each accepted
// command into a store access and produces the result status fields.
// ----------------------------------------------------------------------------
module rbd_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [2:0]                  cmd_i,
  input  wire logic [rbd_pkg::DataW-1:0]   value_in_i,
  output rbd_pkg::mem_req_t                mem_req_o,
  output rbd_pkg::res_t                    res_o
);

  localparam logic [rbd_pkg::PtrW-1:0] PtrLast = rbd_pkg::PtrW'(rbd_pkg::Depth - 1);
  localparam logic [rbd_pkg::CntW-1:0] CntFull = rbd_pkg::CntW'(rbd_pkg::Depth);

  logic [rbd_pkg::PtrW-1:0] front_q, front_d;
  logic [rbd_pkg::PtrW-1:0] rear_q, rear_d;
  logic [rbd_pkg::CntW-1:0] held_q, held_d;
  logic                     full, empty;

  // Pointer steps that wrap at the depth of the ring.
  function automatic logic [rbd_pkg::PtrW-1:0] step_up(input logic [rbd_pkg::PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [rbd_pkg::PtrW-1:0] step_down(input logic [rbd_pkg::PtrW-1:0] p);
    return (p == '0) ? PtrLast : p - 1'b1;
  endfunction

  assign full  = (held_q == CntFull);
  assign empty = (held_q == '0);

  // Command decode: next pointers, count and the store access.
  always_comb begin
    front_d             = front_q;
    rear_d              = rear_q;
    held_d              = held_q;
    mem_req_o.we        = 1'b0;
    mem_req_o.re        = 1'b0;
    mem_req_o.addr      = front_q;
    mem_req_o.wdata     = value_in_i;
    res_o.pop           = 1'b0;
    res_o.status        = rbd_pkg::StDone;
    case (cmd_i)
      rbd_pkg::CmdPushFront: begin
        if (full) begin
          res_o.status = rbd_pkg::StFull;
        end else begin
          front_d        = step_up(front_q);
          mem_req_o.we   = 1'b1;
          mem_req_o.addr = front_d;
          held_d         = held_q + 1'b1;
        end
      end
      rbd_pkg::CmdPopFront: begin
        if (empty) begin
          res_o.status = rbd_pkg::StEmpty;
        end else begin
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = front_q;
          res_o.pop      = 1'b1;
          front_d        = step_down(front_q);
          held_d         = held_q - 1'b1;
        end
      end
      rbd_pkg::CmdPushRear: begin
        if (full) begin
          res_o.status = rbd_pkg::StFull;
        end else begin
          rear_d         = step_down(rear_q);
          mem_req_o.we   = 1'b1;
          mem_req_o.addr = rear_d;
          held_d         = held_q + 1'b1;
        end
      end
      rbd_pkg::CmdPopRear: begin
        if (empty) begin
          res_o.status = rbd_pkg::StEmpty;
        end else begin
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = rear_q;
          res_o.pop      = 1'b1;
          rear_d         = step_up(rear_q);
          held_d         = held_q - 1'b1;
        end
      end
      rbd_pkg::CmdClear: begin
        front_d = PtrLast;
        rear_d  = '0;
        held_d  = '0;
      end
      default: begin
      end
    endcase
    // Nothing touches the store unless the word is actually taken.
    mem_req_o.we = mem_req_o.we & accept_i;
    mem_req_o.re = mem_req_o.re & accept_i;
    res_o.count  = rbd_pkg::CountOutW'(held_d);
    res_o.empty  = (held_d == '0);
    res_o.full   = (held_d == CntFull);
  end

  // Pointer and count registers advance only on an accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= PtrLast;
      rear_q  <= '0;
      held_q  <= '0;
    end else if (accept_i) begin
      front_q <= front_d;
      rear_q  <= rear_d;
      held_q  <= held_d;
    end
  end

  // The count never exceeds the depth of the ring.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CntFull)
    else $error("word count beyond ring depth");

  // A clear empties the deque and restores both pointers.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (cmd_i == rbd_pkg::CmdClear)
    |=> (held_q == '0) && (front_q == PtrLast) && (rear_q == '0))
    else $error("clear did not restore the deque");

  // A refused push leaves the state untouched and writes nothing.
  a_refused_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && full && ((cmd_i == rbd_pkg::CmdPushFront) || (cmd_i == rbd_pkg::CmdPushRear))
    |-> !mem_req_o.we ##1 ($stable(held_q) && $stable(front_q) && $stable(rear_q)))
    else $error("refused push changed the deque");

  // With one word held, front and rear point at the same entry.
  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == rbd_pkg::CntW'(1)) |-> (front_q == rear_q))
    else $error("ends disagree on a single held word");

endmodule
`default_nettype wire

// File: src/ring_buffer_deque.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_buffer_deque: double-ended queue of 32-bit words in a ring store
// Each input word carries one command: push or pop at the front, push or pop
// at the rear, or clear. Every command returns exactly one result word with
// the popped value (zero unless a pop succeeded), a status code (done,
// refused because full, refused because empty) and the count and empty/full
// flags after the command. The store is a single-port memory with registered
// read data; a command is decoded and its store access issued in the cycle it
// is taken, and its result word is presented from the next cycle onwards.
// The block takes one command per cycle while the result side keeps up;
// a stalled result holds off further commands.
// Words in the store are undefined until pushed; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ring_buffer_deque (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [2:0]                cmd_i,
  input  wire logic signed [31:0]        value_in_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed [31:0]             value_out_o,
  output logic [1:0]                     status_o,
  output logic [4:0]                     count_o,
  output logic                           empty_flag_o,
  output logic                           full_flag_o
);

  logic                         accept;
  logic                         out_valid_q;
  rbd_pkg::mem_req_t            mem_req;
  rbd_pkg::res_t                res, res_q;
  logic [rbd_pkg::DataW-1:0]    rdata;

  // A new word is taken whenever the result register is free or draining.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  rbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (cmd_i),
    .value_in_i (value_in_i),
    .mem_req_o  (mem_req),
    .res_o      (res)
  );

  rbd_ram #(
    .Depth (rbd_pkg::Depth),
    .Width (rbd_pkg::DataW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rdata)
  );

  // Result register; the popped word arrives from the store alongside it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_out_o  = res_q.pop ? rdata : '0;
  assign status_o     = res_q.status;
  assign count_o      = res_q.count;
  assign empty_flag_o = res_q.empty;
  assign full_flag_o  = res_q.full;

endmodule
`default_nettype wire

// File: bench/tb_ring_buffer_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_buffer_deque: self-checking bench for the ring buffer deque
// Commands go in through the input channel and every accepted word is run
// through a behavioural deque kept in the bench. The expected result is
// queued, and each result word from the block is checked against the oldest
// one. Directed commands come first. A back-pressure phase then fills both
// the deque and the pipeline, a stretch follows with no idling on either
// side, and a long random walk between the full and empty states ends the
// run. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_ring_buffer_deque;

  // Command codes that the block treats as no operation.
  localparam logic [2:0] CmdSpareFirst = 3'd5;
  localparam logic [2:0] CmdSpareLast  = 3'd7;
  localparam int IdlePercent = 22;
  localparam int MaxReported = 10;

  typedef struct packed {
    logic [rbd_pkg::DataW-1:0]     value;
    rbd_pkg::status_e              status;
    logic [rbd_pkg::CountOutW-1:0] count;
    logic                          empty;
    logic                          full;
  } deque_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           cmd;
  logic signed [31:0]   value_in;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [31:0]   value_out;
  logic [1:0]           status;
  logic [4:0]           count;
  logic                 empty_flag;
  logic                 full_flag;

  // Bench copy of the deque contents and pointers.
  logic [rbd_pkg::DataW-1:0] deque_words [rbd_pkg::Depth];
  int                        front_idx;
  int                        rear_idx;
  int                        held_words;

  deque_result_t pending_results [$];
  int            mismatches;
  bit            calm;
  int            hold_request;
  int            hold_left;

  ring_buffer_deque uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .value_in_i   (value_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .value_out_o  (value_out),
    .status_o     (status),
    .count_o      (count),
    .empty_flag_o (empty_flag),
    .full_flag_o  (full_flag)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Decides whether a side idles this cycle.
  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < IdlePercent);
  endfunction

  // Returns a word, often one of the extremes.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Empties the bench deque, as reset and clear do.
  task automatic clear_deque_model();
    held_words = 0;
    front_idx  = rbd_pkg::Depth - 1;
    rear_idx   = 0;
  endtask

  // Applies one accepted command to the bench deque and queues its result.
  task automatic predict_deque_step(input logic [2:0] c, input logic [31:0] w);
    deque_result_t r;
    bit            is_full;
    bit            none_held;
    r         = '0;
    r.status  = rbd_pkg::StDone;
    is_full   = held_words >= rbd_pkg::Depth;
    none_held = held_words == 0;
    case (c)
      rbd_pkg::CmdPushFront: begin
        if (is_full) begin
          r.status = rbd_pkg::StFull;
        end else begin
          front_idx = (front_idx == rbd_pkg::Depth - 1) ? 0 : front_idx + 1;
          deque_words[front_idx] = w;
          held_words++;
        end
      end
      rbd_pkg::CmdPopFront: begin
        if (none_held) begin
          r.status = rbd_pkg::StEmpty;
        end else begin
          r.value = deque_words[front_idx];
          front_idx = (front_idx == 0) ? rbd_pkg::Depth - 1 : front_idx - 1;
          held_words--;
        end
      end
      rbd_pkg::CmdPushRear: begin
        if (is_full) begin
          r.status = rbd_pkg::StFull;
        end else begin
          rear_idx = (rear_idx == 0) ? rbd_pkg::Depth - 1 : rear_idx - 1;
          deque_words[rear_idx] = w;
          held_words++;
        end
      end
      rbd_pkg::CmdPopRear: begin
        if (none_held) begin
          r.status = rbd_pkg::StEmpty;
        end else begin
          r.value = deque_words[rear_idx];
          rear_idx = (rear_idx == rbd_pkg::Depth - 1) ? 0 : rear_idx + 1;
          held_words--;
        end
      end
      rbd_pkg::CmdClear: begin
        clear_deque_model();
      end
      default: begin
      end
    endcase
    r.count = held_words[rbd_pkg::CountOutW-1:0];
    r.empty = held_words == 0;
    r.full  = held_words >= rbd_pkg::Depth;
    pending_results.push_back(r);
  endtask

  // Offers one command word, with a random gap first, and waits until it is
  // taken. The payload holds steady while the block stalls.
  task automatic send_word(input logic [2:0] c, input logic [31:0] w);
    @(negedge clk);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    value_in <= w;
    do @(posedge clk); while (in_stall);
    predict_deque_step(c, w);
  endtask

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_now();
      end
    end
  end

  // Checks each result word against the oldest expectation.
  always @(posedge clk) begin
    deque_result_t exp_r;
    deque_result_t got_r;
    if (rst_n && out_valid && !out_stall) begin
      got_r = {value_out, rbd_pkg::status_e'(status), count, empty_flag, full_flag};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("%0t: unexpected result value=%h status=%0d count=%0d e=%b f=%b",
                   $realtime, value_out, status, count, empty_flag, full_flag);
      end else begin
        exp_r = pending_results.pop_front();
        if (got_r.value !== exp_r.value || got_r.status !== exp_r.status ||
            got_r.count !== exp_r.count || got_r.empty !== exp_r.empty ||
            got_r.full !== exp_r.full) begin
          mismatches++;
          if (mismatches <= MaxReported) begin
            $display("%0t: mismatch exp value=%h status=%0d count=%0d e=%b f=%b",
                     $realtime, exp_r.value, exp_r.status, exp_r.count, exp_r.empty,
                     exp_r.full);
            $display("%0t:          got value=%h status=%0d count=%0d e=%b f=%b",
                     $realtime, got_r.value, got_r.status, got_r.count, got_r.empty,
                     got_r.full);
          end
        end
      end
    end
  end

  // Empty pops, extreme words, one word seen from both ends, wrap of both
  // pointers, clear and the spare command codes.
  task automatic test_directed();
    send_word(rbd_pkg::CmdPopFront, 32'h0);
    send_word(rbd_pkg::CmdPopRear, 32'h0);
    send_word(rbd_pkg::CmdPushFront, 32'h7fff_ffff);
    send_word(rbd_pkg::CmdPopRear, 32'h0);
    send_word(rbd_pkg::CmdPushRear, 32'h8000_0000);
    send_word(rbd_pkg::CmdPopFront, 32'h0);
    send_word(rbd_pkg::CmdPushFront, 32'h0000_0000);
    send_word(rbd_pkg::CmdPushRear, 32'hffff_ffff);
    send_word(rbd_pkg::CmdPushFront, 32'h0000_0001);
    send_word(rbd_pkg::CmdPopFront, 32'h0);
    send_word(rbd_pkg::CmdPopRear, 32'h0);
    send_word(rbd_pkg::CmdPopFront, 32'h0);
    send_word(rbd_pkg::CmdPopFront, 32'h0);
    send_word(rbd_pkg::CmdPushRear, 32'h1234_5678);
    send_word(rbd_pkg::CmdClear, 32'h0);
    send_word(rbd_pkg::CmdPopRear, 32'h0);
    for (int c = CmdSpareFirst; c <= CmdSpareLast; c++) send_word(c[2:0], $urandom);
    send_word(rbd_pkg::CmdPushFront, 32'ha5a5_a5a5);
    send_word(rbd_pkg::CmdPushRear, 32'h5a5a_5a5a);
    send_word(rbd_pkg::CmdPopRear, 32'h0);
    send_word(rbd_pkg::CmdPopFront, 32'h0);
  endtask

  // The receiver holds off while commands keep coming, so the block stalls
  // its input; the deque is then filled past full and drained past empty.
  task automatic test_fill_under_backpressure();
    hold_request = 80;
    for (int i = 0; i < rbd_pkg::Depth + 4; i++)
      send_word($urandom_range(1) ? rbd_pkg::CmdPushFront : rbd_pkg::CmdPushRear,
                pick_word());
    for (int i = 0; i < rbd_pkg::Depth + 4; i++)
      send_word($urandom_range(1) ? rbd_pkg::CmdPopFront : rbd_pkg::CmdPopRear, 32'h0);
  endtask

  // A stretch in which neither side idles.
  task automatic test_back_to_back();
    calm = 1'b1;
    for (int i = 0; i < 200; i++)
      send_word(3'($urandom_range(rbd_pkg::CmdPopRear)), pick_word());
    calm = 1'b0;
  endtask

  // Random walk that swings between push-heavy and pop-heavy runs so that
  // both the full and the empty state are reached often.
  task automatic test_random_walk();
    int push_share;
    int r;
    push_share = 75;
    for (int i = 0; i < 1200; i++) begin
      if (i % 40 == 0) push_share = 100 - push_share;
      r = $urandom_range(99);
      if (r < 2)
        send_word(rbd_pkg::CmdClear, $urandom);
      else if (r < 3)
        send_word(3'($urandom_range(CmdSpareLast, CmdSpareFirst)), $urandom);
      else if ($urandom_range(99) < push_share)
        send_word($urandom_range(1) ? rbd_pkg::CmdPushFront : rbd_pkg::CmdPushRear,
                  pick_word());
      else
        send_word($urandom_range(1) ? rbd_pkg::CmdPopFront : rbd_pkg::CmdPopRear,
                  pick_word());
    end
  endtask

  // Watchdog for a hung run.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Reset, run the tests in turn, drain and report.
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    cmd          = rbd_pkg::CmdPushFront;
    value_in     = '0;
    mismatches   = 0;
    calm         = 1'b0;
    hold_request = 0;
    for (int i = 0; i < rbd_pkg::Depth; i++) deque_words[i] = '0;
    clear_deque_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_fill_under_backpressure();
    test_back_to_back();
    test_random_walk();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/rbd_pkg.sv
src/rbd_ram.sv
src/rbd_ctrl.sv
src/ring_buffer_deque.sv
bench/tb_ring_buffer_deque.sv
